// ----- rtl/iwd_pkg.sv -----
// iwd_pkg: decode table, format codes and sizing constants for the instruction word decoder
// depends on nothing; used by instruction_word_decoder_core
package iwd_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_ENTRIES = 51;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned GRP_W      = 3;
  localparam int unsigned GRP_SIZE   = 1 << GRP_W;
  localparam int unsigned NUM_GRPS   = (NUM_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GSEL_W     = IDX_W - GRP_W;
  localparam int unsigned MATCH_W    = NUM_GRPS * GRP_SIZE;

  // table position of bnez, which bne always shadows
  localparam logic [IDX_W-1:0] IDX_BNEZ = 6'd14;

  typedef enum logic [2:0] {
    FMT_IMM    = 3'd0,
    FMT_JUMP   = 3'd1,
    FMT_LOAD   = 3'd2,
    FMT_STORE  = 3'd3,
    FMT_REG    = 3'd4,
    FMT_SHIFT  = 3'd5,
    FMT_REG4   = 3'd6,
    FMT_SINGLE = 3'd7
  } fmt_t;

  localparam logic [WORD_W-1:0] ENTRY_PAT [NUM_ENTRIES] = '{
    32'h04000000, 32'h00000001, 32'h00000002, 32'h08000000, 32'h14000000,
    32'h00000005, 32'h0000000E, 32'h0000000E, 32'h0000000E, 32'h00000011,
    32'h00000011, 32'h00000010, 32'h00000010, 32'h0000000F, 32'h0000000F,
    32'h0000000D, 32'h18000000, 32'h1C000000, 32'h0000000A, 32'h00000009,
    32'h0000000C, 32'h0001000C, 32'h00010009, 32'h0000000B, 32'h00020009,
    32'h58000000, 32'h50000000, 32'h20000000, 32'h24000000, 32'hF800003F,
    32'hFC00003F, 32'h00000000, 32'h28000000, 32'h2C000000, 32'h00000006,
    32'h00000008, 32'h00010008, 32'h34000000, 32'h40000000, 32'h3C000000,
    32'h44000000, 32'h38000000, 32'h48000000, 32'h0C000000, 32'h00000003,
    32'h00000004, 32'h10000000, 32'h00020008, 32'hFC000000, 32'h30000000,
    32'h00000007
  };

  localparam logic [WORD_W-1:0] ENTRY_SEL [NUM_ENTRIES] = '{
    32'hFC00003F, 32'h0000003F, 32'h0000003F, 32'hFC00003F, 32'hFC00003F,
    32'h0000003F, 32'h0000FFFF, 32'h0000003F, 32'h0000F83F, 32'h0000003F,
    32'h0000F83F, 32'h0000003F, 32'h0000F83F, 32'h0000003F, 32'h0000003F,
    32'h0000003F, 32'hFC00003F, 32'hFC00003F, 32'h0000003F, 32'h0003003F,
    32'h0003003F, 32'h0003003F, 32'h0003003F, 32'h0000F83F, 32'h0003003F,
    32'hFC00003F, 32'hFC00003F, 32'hFC00003F, 32'hFC00003F, 32'hFC00003F,
    32'hFC00003F, 32'hFFFFFFFF, 32'hFC00003F, 32'hFC00003F, 32'h0000003F,
    32'h0003003F, 32'h0003003F, 32'hFC00003F, 32'hFC00003F, 32'hFC00003F,
    32'hFC00003F, 32'hFC00003F, 32'hFC00003F, 32'hFC00003F, 32'h0000003F,
    32'h0000003F, 32'hFC00003F, 32'h0003003F, 32'hFC00003F, 32'hFC00003F,
    32'h0000003F
  };

  localparam fmt_t ENTRY_FMT [NUM_ENTRIES] = '{
    FMT_REG,    FMT_IMM,   FMT_IMM,   FMT_REG,   FMT_REG,
    FMT_IMM,    FMT_IMM,   FMT_IMM,   FMT_IMM,   FMT_IMM,
    FMT_IMM,    FMT_IMM,   FMT_IMM,   FMT_IMM,   FMT_IMM,
    FMT_JUMP,   FMT_REG,   FMT_REG,   FMT_JUMP,  FMT_LOAD,
    FMT_LOAD,   FMT_LOAD,  FMT_LOAD,  FMT_IMM,   FMT_LOAD,
    FMT_REG,    FMT_REG,   FMT_REG4,  FMT_REG4,  FMT_REG,
    FMT_REG,    FMT_SINGLE, FMT_REG,  FMT_REG,   FMT_IMM,
    FMT_STORE,  FMT_STORE, FMT_SHIFT, FMT_REG,   FMT_SHIFT,
    FMT_REG,    FMT_SHIFT, FMT_REG,   FMT_REG,   FMT_IMM,
    FMT_IMM,    FMT_REG,   FMT_STORE, FMT_SINGLE, FMT_REG,
    FMT_IMM
  };

  // format of a table slot, slots past the table end read as imm
  function automatic fmt_t entry_fmt(input logic [IDX_W-1:0] idx);
    fmt_t f;
    f = FMT_IMM;
    if (idx < IDX_W'(NUM_ENTRIES)) begin
      f = ENTRY_FMT[idx];
    end
    return f;
  endfunction

endpackage

// ----- rtl/instruction_word_decoder_core.sv -----
// instruction_word_decoder_core: three-stage pipelined first-match instruction decoder
// depends on iwd_pkg (decode table, format codes, sizing constants)
// throughput: one beat per cycle while out_stall is low; the match, group-encode and select stages each hold one word
// in_stall rises only when all three stages hold a beat and the output side stalls
// reset: synchronous active-low rst_n clears the stage valid bits, payload is not reset
module instruction_word_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [iwd_pkg::WORD_W-1:0]    in_instr_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [iwd_pkg::IDX_W-1:0]     out_op_index,
  output logic [2:0]                    out_format_class,
  output logic [4:0]                    out_reg_a,
  output logic [4:0]                    out_reg_b,
  output logic [4:0]                    out_reg_c,
  output logic [4:0]                    out_reg_d,
  output logic [15:0]                   out_imm_value,
  output logic [20:0]                   out_jump_offset,
  output logic [13:0]                   out_mem_offset,
  output logic [4:0]                    out_shift_amount
);

  localparam int unsigned NG = iwd_pkg::NUM_GRPS;
  localparam int unsigned GS = iwd_pkg::GRP_SIZE;

  // stage valid bits
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic adv1, adv2, adv3;

  // stage 1: word and raw match vector
  logic [iwd_pkg::WORD_W-1:0]  word1_r, word1_nxt;
  logic [iwd_pkg::MATCH_W-1:0] match1_r, match1_nxt;

  // stage 2: per-group first hit
  logic [iwd_pkg::WORD_W-1:0]  word2_r, word2_nxt;
  logic [NG-1:0]               ghit2_r, ghit2_nxt;
  logic [iwd_pkg::GRP_W-1:0]   gidx2_r [NG];
  logic [iwd_pkg::GRP_W-1:0]   gidx2_nxt [NG];

  // stage 3: output register
  logic                        hit3_r, hit3_nxt;
  logic [iwd_pkg::IDX_W-1:0]   idx3_r, idx3_nxt;
  iwd_pkg::fmt_t               fmt3_r, fmt3_nxt;
  logic [iwd_pkg::WORD_W-1:0]  word3_r, word3_nxt;

  logic [iwd_pkg::GSEL_W-1:0]  gsel;
  logic                        any_hit;

  // a stage moves when it is empty or its successor moves
  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;
  assign v3_nxt = adv3 ? v2_r : v3_r;

  always_comb begin
    match1_nxt = '0;
    for (int k = 0; k < iwd_pkg::NUM_ENTRIES; k++) begin
      match1_nxt[k] = (in_instr_word & iwd_pkg::ENTRY_SEL[k]) == iwd_pkg::ENTRY_PAT[k];
    end
    word1_nxt = in_instr_word;
  end

  // lowest set bit within each group of eight
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      ghit2_nxt[g] = |match1_r[g*GS +: GS];
      gidx2_nxt[g] = '0;
      for (int j = GS - 1; j >= 0; j--) begin
        if (match1_r[g*GS + j]) begin
          gidx2_nxt[g] = iwd_pkg::GRP_W'(j);
        end
      end
    end
    word2_nxt = word1_r;
  end

  // lowest group with a hit wins
  always_comb begin
    gsel    = '0;
    any_hit = |ghit2_r;
    for (int g = NG - 1; g >= 0; g--) begin
      if (ghit2_r[g]) begin
        gsel = iwd_pkg::GSEL_W'(g);
      end
    end
    hit3_nxt  = any_hit;
    idx3_nxt  = any_hit ? {gsel, gidx2_r[gsel]} : '0;
    fmt3_nxt  = any_hit ? iwd_pkg::entry_fmt({gsel, gidx2_r[gsel]}) : iwd_pkg::FMT_IMM;
    word3_nxt = any_hit ? word2_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      word1_r  <= word1_nxt;
      match1_r <= match1_nxt;
    end
    if (adv2) begin
      word2_r <= word2_nxt;
      ghit2_r <= ghit2_nxt;
      for (int g = 0; g < NG; g++) begin
        gidx2_r[g] <= gidx2_nxt[g];
      end
    end
    if (adv3) begin
      hit3_r  <= hit3_nxt;
      idx3_r  <= idx3_nxt;
      fmt3_r  <= fmt3_nxt;
      word3_r <= word3_nxt;
    end
  end

  // operand fields come straight from the held word, zeroed on a miss
  assign out_valid        = v3_r;
  assign out_hit          = hit3_r;
  assign out_op_index     = idx3_r;
  assign out_format_class = 3'(fmt3_r);
  assign out_reg_a        = word3_r[10:6];
  assign out_reg_b        = word3_r[15:11];
  assign out_reg_c        = word3_r[20:16];
  assign out_reg_d        = word3_r[25:21];
  assign out_imm_value    = word3_r[31:16];
  assign out_jump_offset  = word3_r[31:11];
  assign out_mem_offset   = word3_r[31:18];
  assign out_shift_amount = word3_r[25:21];

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_op_index == '0
                                 && out_format_class == 3'(iwd_pkg::FMT_IMM)
                                 && out_imm_value == '0 && out_jump_offset == '0))
    else $error("miss beat carries nonzero fields");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_op_index < iwd_pkg::IDX_W'(iwd_pkg::NUM_ENTRIES)))
    else $error("op index past table end");

  a_shadowed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_op_index != iwd_pkg::IDX_BNEZ))
    else $error("shadowed entry reported as match");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_stall))
    else $error("input stalled with room in pipeline");

  a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !v3_r) |=> v3_r)
    else $error("beat failed to advance into empty output stage");

endmodule
